FILE: hw/rtl/gsse_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gsse_pkg
// Shared types and constants of the game pad serial shift emulator.
// ----------------------------------------------------------------------------
package gsse_pkg;

	localparam int unsigned FUNC_W    = 2;
	localparam int unsigned INDEX_W   = 4;
	localparam int unsigned VALUE_W   = 32;
	localparam int unsigned SENT_W    = 5;

	// Item kinds carried in the func field.
	localparam logic [FUNC_W-1:0] FUNC_UPDATE = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_LATCH  = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_CLOCK  = 2'd2;

	localparam logic [VALUE_W-1:0] THRESHOLD_RESET = 32'h7FFF_FFFF;

	typedef struct packed {
		logic [FUNC_W-1:0]  func;
		logic [INDEX_W-1:0] button_index;
		logic [VALUE_W-1:0] button_value;
		logic               latch_level;
	} item_t;

	// One item leaving the input register towards the state logic.
	typedef struct packed {
		logic  fire;
		item_t item;
	} step_t;

endpackage : gsse_pkg
`default_nettype wire

FILE: hw/rtl/gsse_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gsse_if
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface gsse_in_if;
	logic                          valid;
	logic                          ready;
	logic [gsse_pkg::FUNC_W-1:0]   func;
	logic [gsse_pkg::INDEX_W-1:0]  button_index;
	logic [gsse_pkg::VALUE_W-1:0]  button_value;
	logic                          latch_level;

	modport source (output valid, func, button_index, button_value, latch_level,
		input ready);
	modport sink (input valid, func, button_index, button_value, latch_level,
		output ready);
endinterface : gsse_in_if

interface gsse_out_if;
	logic                          valid;
	logic                          ready;
	logic                          data_out;
	logic [gsse_pkg::SENT_W-1:0]   bits_sent;

	modport source (output valid, data_out, bits_sent, input ready);
	modport sink (input valid, data_out, bits_sent, output ready);
endinterface : gsse_out_if
`default_nettype wire

FILE: hw/rtl/gsse_button_bank.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gsse_button_bank
// Button level store, threshold register and the compare bank that turns
// the levels into one released bit per button.
// ----------------------------------------------------------------------------
module gsse_button_bank #(
	parameter int unsigned BUTTON_COUNT = 16
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_wr_en,
	input  wire logic [gsse_pkg::VALUE_W-1:0]   cfg_wr_data,
	input  wire gsse_pkg::step_t                step,
	output      logic [BUTTON_COUNT-1:0]        released
);

	logic [gsse_pkg::VALUE_W-1:0] threshold_q;
	logic [gsse_pkg::VALUE_W-1:0] values_q [BUTTON_COUNT];
	logic                         update;

	assign update = step.fire && (step.item.func == gsse_pkg::FUNC_UPDATE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= gsse_pkg::THRESHOLD_RESET;
		end else if (cfg_wr_en) begin
			threshold_q <= cfg_wr_data;
		end
	end

	// Each entry decodes its own write; indexes beyond the bank match nothing.
	for (genvar i = 0; i < BUTTON_COUNT; i++) begin : g_entry
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				values_q[i] <= '0;
			end else if (update && (32'(step.item.button_index) == i)) begin
				values_q[i] <= step.item.button_value;
			end
		end

		assign released[i] = (values_q[i] <= threshold_q);
	end

endmodule : gsse_button_bank
`default_nettype wire

FILE: hw/rtl/gsse_shifter.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gsse_shifter
// Latch edge tracking, captured frame and serial bit position.
// ----------------------------------------------------------------------------
module gsse_shifter #(
	parameter int unsigned BUTTON_COUNT = 16
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire gsse_pkg::step_t                  step,
	input  wire logic [BUTTON_COUNT-1:0]          released,
	output      logic                             data_d,
	output      logic [$clog2(BUTTON_COUNT+1)-1:0] pos_d
);

	localparam int unsigned POS_W = $clog2(BUTTON_COUNT + 1);
	localparam int unsigned SEL_W = $clog2(BUTTON_COUNT);

	logic [BUTTON_COUNT-1:0] captured_q, captured_d;
	logic [POS_W-1:0]        pos_q;
	logic                    known_q, known_d;
	logic                    tracked_q, tracked_d;
	logic                    data_q;
	logic                    bit_left;

	assign bit_left = (32'(pos_q) < BUTTON_COUNT);

	always_comb begin
		captured_d = captured_q;
		pos_d      = pos_q;
		known_d    = known_q;
		tracked_d  = tracked_q;
		data_d     = data_q;
		if (step.fire) begin
			unique case (step.item.func)
				gsse_pkg::FUNC_UPDATE: begin
				end
				gsse_pkg::FUNC_LATCH: begin
					known_d   = 1'b1;
					tracked_d = known_q ? !tracked_q : step.item.latch_level;
					if (tracked_d) begin
						captured_d = released;
						pos_d      = '0;
					end else if (bit_left) begin
						data_d = captured_q[pos_q[SEL_W-1:0]];
						pos_d  = POS_W'(pos_q + 1'b1);
					end else begin
						data_d = 1'b0;
					end
				end
				gsse_pkg::FUNC_CLOCK: begin
					if (bit_left) begin
						data_d = captured_q[pos_q[SEL_W-1:0]];
						pos_d  = POS_W'(pos_q + 1'b1);
					end else begin
						data_d = 1'b0;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			captured_q <= '0;
			pos_q      <= POS_W'(BUTTON_COUNT);
			known_q    <= 1'b0;
			tracked_q  <= 1'b0;
			data_q     <= 1'b0;
		end else begin
			captured_q <= captured_d;
			pos_q      <= pos_d;
			known_q    <= known_d;
			tracked_q  <= tracked_d;
			data_q     <= data_d;
		end
	end

endmodule : gsse_shifter
`default_nettype wire

FILE: hw/rtl/gamepad_serial_shift_emulator_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gamepad_serial_shift_emulator_top
// Console-side model of a game pad's parallel-in serial-out button register.
// ----------------------------------------------------------------------------
// The block takes one item per clock cycle while the result channel is not
// stalled, and returns exactly one result beat for each item. An item
// travels through two registers: the input register, and then the result
// register, which it enters in the same cycle as the button store and the
// frame state are updated. The result beat is presented once its item has
// passed both registers. Each item makes a single state update: the compare
// bank of BUTTON_COUNT threshold comparators (for a rising latch edge) or the
// one-bit shift selection (for a falling latch or clock edge) sits between
// the input register and the result register. A stall on the result side
// holds the input register, and the input channel drops ready only when both
// registers are full and the result beat is not taken in that cycle. The
// threshold register may be written at any time the block is idle and takes
// effect for the next latch capture.
// ----------------------------------------------------------------------------
module gamepad_serial_shift_emulator_top #(
	parameter int unsigned BUTTON_COUNT = 16
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         cfg_wr_en,
	input  wire logic [gsse_pkg::VALUE_W-1:0] cfg_wr_data,
	gsse_in_if.sink                           item,
	gsse_out_if.source                        result
);

	localparam int unsigned POS_W = $clog2(BUTTON_COUNT + 1);

	// Input register stage.
	logic              v_s1;
	gsse_pkg::item_t   item_s1;

	// Result register.
	logic                         res_v_q;
	logic                         res_data_q;
	logic [gsse_pkg::SENT_W-1:0]  res_sent_q;

	logic                    advance;
	gsse_pkg::step_t         step;
	logic [BUTTON_COUNT-1:0] released;
	logic                    data_d;
	logic [POS_W-1:0]        pos_d;

	// The stage moves on when the result register is empty or is being
	// drained in this cycle; the input side also takes an item when empty.
	assign advance    = !res_v_q || result.ready;
	assign item.ready = !v_s1 || advance;

	assign step.fire = v_s1 && advance;
	assign step.item = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (item.ready) begin
			v_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.ready && item.valid) begin
			item_s1.func         <= item.func;
			item_s1.button_index <= item.button_index;
			item_s1.button_value <= item.button_value;
			item_s1.latch_level  <= item.latch_level;
		end
	end

	gsse_button_bank #(
		.BUTTON_COUNT (BUTTON_COUNT)
	) u_bank (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.step        (step),
		.released    (released)
	);

	gsse_shifter #(
		.BUTTON_COUNT (BUTTON_COUNT)
	) u_shifter (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (step),
		.released (released),
		.data_d   (data_d),
		.pos_d    (pos_d)
	);

	// The result beat carries the pin level and bit count after the item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_v_q <= 1'b0;
		end else if (step.fire) begin
			res_v_q <= 1'b1;
		end else if (result.ready) begin
			res_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step.fire) begin
			res_data_q <= data_d;
			res_sent_q <= gsse_pkg::SENT_W'(pos_d);
		end
	end

	assign result.valid     = res_v_q;
	assign result.data_out  = res_data_q;
	assign result.bits_sent = res_sent_q;

endmodule : gamepad_serial_shift_emulator_top
`default_nettype wire
